// ===== rtl/sfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, constants and the bytewise CRC-16/CCITT-FALSE update for the
// status frame checker.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam logic [7:0]  HDR_BYTE0      = 8'h55;
  localparam logic [7:0]  HDR_BYTE1      = 8'hAA;
  localparam logic [7:0]  CODE_READ      = 8'h81;
  localparam logic [7:0]  CODE_WRITE     = 8'h82;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [9:0]  BATT_MAX_TENTH = 10'd1000;
  localparam logic [6:0]  BATT_MAX_PCT   = 7'd100;
  // raw value from which the whole percent is forced to its ceiling
  localparam logic [15:0] BATT_PCT_SAT   = 16'd1010;
  // n / 10 == (n * 205) >> 11 for every n below 1029
  localparam logic [7:0]  DIV10_MULT     = 8'd205;
  localparam int unsigned DIV10_SHIFT    = 11;

  // byte positions inside a frame
  localparam int unsigned POS_HDR1   = 1;
  localparam int unsigned POS_CODE   = 2;
  localparam int unsigned POS_TEMP_L = 3;
  localparam int unsigned POS_TEMP_H = 4;
  localparam int unsigned POS_BATT_L = 7;
  localparam int unsigned POS_BATT_H = 8;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_BAD_CODE   = 3'd2,
    ST_CRC_ERR    = 3'd3,
    ST_SHORT      = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        is_write;
    logic [15:0] temp;
    logic [9:0]  tenths;
    logic [6:0]  pct;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sfc_batt_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_batt_scale
// Battery word to saturated tenths and saturated whole percent.
// ----------------------------------------------------------------------------
module sfc_batt_scale (
  input  wire logic [15:0] batt_word,
  output logic      [9:0]  batt_tenths,
  output logic      [6:0]  batt_pct
);

  logic [18:0] prod;
  logic [7:0]  quot;

  // only used below the saturation point, so 11 bits of the word suffice
  assign prod = 19'(batt_word[10:0]) * 19'(sfc_pkg::DIV10_MULT);
  assign quot = prod[sfc_pkg::DIV10_SHIFT +: 8];

  always_comb begin
    if (batt_word > 16'(sfc_pkg::BATT_MAX_TENTH)) begin
      batt_tenths = sfc_pkg::BATT_MAX_TENTH;
    end else begin
      batt_tenths = batt_word[9:0];
    end
    if (batt_word >= sfc_pkg::BATT_PCT_SAT) begin
      batt_pct = sfc_pkg::BATT_MAX_PCT;
    end else begin
      batt_pct = quot[6:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sfc_frame.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_frame
// Frame tracker: byte position, running CRC, field capture and the end of
// frame checks. State moves on each advanced item; the result is combinational.
// ----------------------------------------------------------------------------
module sfc_frame #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 item_go,
  input  wire logic [7:0]           item_byte,
  input  wire logic                 item_start,
  output logic                      res_valid,
  output sfc_pkg::result_t          res
);

  localparam int unsigned POS_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] CRC_LO_POS = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_ONE    = POS_W'(1);

  logic             open_r,   open_nxt;
  logic [POS_W-1:0] pos_r,    pos_nxt;
  logic [15:0]      crc_r,    crc_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic [7:0]       code_r,   code_nxt;
  logic [15:0]      temp_r,   temp_nxt;
  logic [15:0]      batt_r,   batt_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;

  logic [15:0] crc_upd;
  logic [9:0]  batt_tenths;
  logic [6:0]  batt_pct;

  assign crc_upd = sfc_pkg::crc_feed(item_start ? sfc_pkg::CRC_INIT : crc_r, item_byte);

  sfc_batt_scale u_batt (
    .batt_word   (batt_r),
    .batt_tenths (batt_tenths),
    .batt_pct    (batt_pct)
  );

  always_comb begin
    open_nxt   = open_r;
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    hdr_ok_nxt = hdr_ok_r;
    code_nxt   = code_r;
    temp_nxt   = temp_r;
    batt_nxt   = batt_r;
    crc_lo_nxt = crc_lo_r;
    res_valid  = 1'b0;
    res        = '{status: sfc_pkg::ST_OK, is_write: 1'b0, temp: 16'd0,
                   tenths: 10'd0, pct: 7'd0};

    if (item_start) begin
      // a start inside an open frame reports the cut frame first
      if (open_r) begin
        res_valid  = 1'b1;
        res.status = sfc_pkg::ST_SHORT;
      end
      open_nxt   = 1'b1;
      pos_nxt    = POS_ONE;
      crc_nxt    = crc_upd;
      hdr_ok_nxt = (item_byte == sfc_pkg::HDR_BYTE0);
    end else if (open_r) begin
      if (pos_r < CRC_LO_POS) begin
        crc_nxt = crc_upd;
      end
      if (pos_r == POS_W'(sfc_pkg::POS_HDR1)) begin
        hdr_ok_nxt = hdr_ok_r & (item_byte == sfc_pkg::HDR_BYTE1);
      end
      if (pos_r == POS_W'(sfc_pkg::POS_CODE)) begin
        code_nxt = item_byte;
      end
      if (pos_r == POS_W'(sfc_pkg::POS_TEMP_L)) begin
        temp_nxt[7:0] = item_byte;
      end
      if (pos_r == POS_W'(sfc_pkg::POS_TEMP_H)) begin
        temp_nxt[15:8] = item_byte;
      end
      if (pos_r == POS_W'(sfc_pkg::POS_BATT_L)) begin
        batt_nxt[7:0] = item_byte;
      end
      if (pos_r == POS_W'(sfc_pkg::POS_BATT_H)) begin
        batt_nxt[15:8] = item_byte;
      end
      if (pos_r == CRC_LO_POS) begin
        crc_lo_nxt = item_byte;
      end

      if (pos_r == LAST_POS) begin
        res_valid = 1'b1;
        if (!hdr_ok_r) begin
          res.status = sfc_pkg::ST_BAD_HEADER;
        end else if (code_r != sfc_pkg::CODE_READ && code_r != sfc_pkg::CODE_WRITE) begin
          res.status = sfc_pkg::ST_BAD_CODE;
        end else if ({item_byte, crc_lo_r} != crc_r) begin
          res.status = sfc_pkg::ST_CRC_ERR;
        end else begin
          res.status   = sfc_pkg::ST_OK;
          res.is_write = (code_r == sfc_pkg::CODE_WRITE);
          res.temp     = temp_r;
          res.tenths   = batt_tenths;
          res.pct      = batt_pct;
        end
        open_nxt = 1'b0;
        pos_nxt  = '0;
        crc_nxt  = sfc_pkg::CRC_INIT;
      end else begin
        pos_nxt = pos_r + POS_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      pos_r    <= '0;
      crc_r    <= sfc_pkg::CRC_INIT;
      hdr_ok_r <= 1'b0;
    end else if (item_go) begin
      open_r   <= open_nxt;
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      hdr_ok_r <= hdr_ok_nxt;
    end
  end

  // every data field is written before the frame end reads it
  always_ff @(posedge clk) begin
    if (item_go) begin
      code_r   <= code_nxt;
      temp_r   <= temp_nxt;
      batt_r   <= batt_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/status_frame_checker_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// status_frame_checker_core
// Checks fixed-length device reply frames received one byte per item.
// An accepted byte enters the input register; its result enters the result
// register. One byte per cycle unless out_stall holds a result; the two
// registers let the next byte in while a result waits to be taken.
// Reset (rst_n low, synchronous): no frame open, CRC at 0xFFFF, no result.
// ----------------------------------------------------------------------------
module status_frame_checker_core #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_rx_byte,
  input  wire logic               in_frame_start,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_frame_status,
  output logic                    out_reply_is_write,
  output logic signed [15:0]      out_temperature_tenths,
  output logic [9:0]              out_battery_tenths,
  output logic [6:0]              out_battery_percent
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;
  logic       advance;
  logic       in_take;

  logic             res_valid;
  sfc_pkg::result_t res;

  logic             out_valid_r;
  sfc_pkg::result_t out_r;

  // the input stage moves on whenever the result register is free or emptying
  assign advance  = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~advance;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_rx_byte;
      s1_start_r <= in_frame_start;
    end
  end

  sfc_frame #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_go    (advance),
    .item_byte  (s1_byte_r),
    .item_start (s1_start_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_frame_status       = out_r.status;
  assign out_reply_is_write     = out_r.is_write;
  assign out_temperature_tenths = out_r.temp;
  assign out_battery_tenths     = out_r.tenths;
  assign out_battery_percent    = out_r.pct;

endmodule
`default_nettype wire
